// ----- hdl/thsq_pkg.sv -----
// Shared types, codes and constants of the traverse homing and winding sequencer.
`timescale 1ns / 1ps
`default_nettype none

package thsq_pkg;

   // Position word and fixed distances
   localparam int POS_WIDTH      = 24;
   localparam int PULL_OFF_WIDTH = 16;
   localparam int SEEK_DISTANCE  = 100000;
   localparam int CSR_IDX_WIDTH  = 2;

   typedef logic signed [POS_WIDTH-1:0] pos_type;

   localparam pos_type SEEK_POS = pos_type'(SEEK_DISTANCE);
   localparam pos_type SEEK_NEG = pos_type'(-SEEK_DISTANCE);

   // Register reset values
   localparam pos_type                   FIRST_LIMIT_RESET  = pos_type'(0);
   localparam pos_type                   SECOND_LIMIT_RESET = pos_type'(500);
   localparam logic [PULL_OFF_WIDTH-1:0] PULL_OFF_RESET     = PULL_OFF_WIDTH'(20);

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_FIRST_LIMIT  = 2'd0,
      CSR_SECOND_LIMIT = 2'd1,
      CSR_PULL_OFF     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      REQ_PLAIN = 3'd0,
      REQ_HOME  = 3'd1,
      REQ_START = 3'd2,
      REQ_STOP  = 3'd3,
      REQ_JOG   = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_STOP     = 3'd1,
      ACT_MOVE_BY  = 3'd2,
      ACT_MOVE_TO  = 3'd3,
      ACT_SET_MOVE = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      SPEED_KEEP      = 3'd0,
      SPEED_FULL      = 3'd1,
      SPEED_HALF      = 3'd2,
      SPEED_QUARTER   = 3'd3,
      SPEED_TWENTIETH = 3'd4,
      SPEED_FIFTH     = 3'd5
   } speed_type;

   typedef enum logic [1:0] {
      SPIN_NONE = 2'd0,
      SPIN_RUN  = 2'd1,
      SPIN_STOP = 2'd2
   } spindle_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_HOMING = 2'd1,
      MODE_RUN    = 2'd2,
      MODE_JOG    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REPLY_OK         = 2'd0,
      REPLY_NOT_HOMED  = 2'd1,
      REPLY_BUSY       = 2'd2
   } reply_type;

   typedef enum logic [2:0] {
      PH_FAST_SEEK  = 3'd0,
      PH_WAIT_FAST  = 3'd1,
      PH_PULL_AWAY  = 3'd2,
      PH_WAIT_PULL  = 3'd3,
      PH_SLOW_SEEK  = 3'd4,
      PH_WAIT_SLOW  = 3'd5,
      PH_PULL_OFF   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [2:0] req_type;
      pos_type    jog_steps;
      logic       estop_active;
      logic       left_switch_hit;
      logic       right_switch_hit;
      logic       left_idle;
      logic       right_idle;
      pos_type    left_position;
   } req_payload_type;

   typedef struct packed {
      action_type  left_action;
      action_type  right_action;
      pos_type     move_offset;
      pos_type     move_target;
      pos_type     set_value;
      speed_type   speed_code;
      spindle_type spindle_action;
      mode_type    mode_now;
      logic        is_homed;
      reply_type   reply;
   } rsp_payload_type;

   // Pipeline control from the input register
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctrl_type;

endpackage

`default_nettype wire

// ----- hdl/thsq_if.sv -----
// Valid/ready channel interfaces for control passes and their results.
`timescale 1ns / 1ps
`default_nettype none

interface thsq_req_if;
   logic                      valid;
   logic                      ready;
   thsq_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface thsq_rsp_if;
   logic                      valid;
   logic                      ready;
   thsq_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/thsq_input_stage.sv -----
// Input register: holds one control pass until the decision logic takes it.
`timescale 1ns / 1ps
`default_nettype none

module thsq_input_stage (
   input  wire logic                       clock,
   input  wire logic                       reset,
   thsq_req_if.sink                        req_if,
   input  wire logic                       can_load,
   output thsq_pkg::stage_ctrl_type        ctrl,
   output thsq_pkg::req_payload_type       item
);

   logic                      valid_ff;
   logic                      valid_in;
   thsq_pkg::req_payload_type item_ff;
   logic                      take;
   logic                      advance;

   // Advance when the result register can take the outcome
   assign advance      = valid_ff && can_load;
   assign req_if.ready = !valid_ff || can_load;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload on each transfer
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_if.payload;
      end
   end

   assign ctrl.valid   = valid_ff;
   assign ctrl.advance = advance;
   assign item         = item_ff;

endmodule

`default_nettype wire

// ----- hdl/thsq_core.sv -----
// Sequencer state, configuration registers and the single-pass decision logic.
`timescale 1ns / 1ps
`default_nettype none

module thsq_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire thsq_pkg::stage_ctrl_type               ctrl,
   input  wire thsq_pkg::req_payload_type              item,
   input  wire logic                                   csr_wr_en,
   input  wire logic [thsq_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  wire logic [thsq_pkg::POS_WIDTH-1:0]         csr_wdata,
   output thsq_pkg::rsp_payload_type                   result
);

   // Configuration registers
   thsq_pkg::pos_type                         first_limit_ff;
   thsq_pkg::pos_type                         second_limit_ff;
   logic [thsq_pkg::PULL_OFF_WIDTH-1:0]       pull_off_ff;

   // Sequencer state
   thsq_pkg::mode_type  mode_ff,       mode_in;
   thsq_pkg::phase_type phase_ff,      phase_in;
   logic                homed_ff,      homed_in;
   logic                home_pend_ff,  home_pend_in;
   logic                start_pend_ff, start_pend_in;
   logic                jog_pend_ff,   jog_pend_in;
   thsq_pkg::pos_type   jog_dist_ff,   jog_dist_in;

   // Pass working values
   thsq_pkg::pos_type     lo, hi, pull_off_ext, tgt;
   thsq_pkg::pos_type     pos, offset, target, setv;
   thsq_pkg::action_type  act0, act1;
   thsq_pkg::speed_type   speed;
   thsq_pkg::spindle_type spin;
   thsq_pkg::reply_type   reply;
   logic                  idle0, idle1, moved0, moved1, both;

   // Order the traverse limits
   assign lo = (first_limit_ff < second_limit_ff) ? first_limit_ff : second_limit_ff;
   assign hi = (first_limit_ff < second_limit_ff) ? second_limit_ff : first_limit_ff;
   assign pull_off_ext =
      {{(thsq_pkg::POS_WIDTH-thsq_pkg::PULL_OFF_WIDTH){1'b0}}, pull_off_ff};

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_limit_ff  <= thsq_pkg::FIRST_LIMIT_RESET;
         second_limit_ff <= thsq_pkg::SECOND_LIMIT_RESET;
         pull_off_ff     <= thsq_pkg::PULL_OFF_RESET;
      end else if (csr_wr_en) begin
         unique case (thsq_pkg::csr_index_type'(csr_index))
            thsq_pkg::CSR_FIRST_LIMIT:  first_limit_ff  <= csr_wdata;
            thsq_pkg::CSR_SECOND_LIMIT: second_limit_ff <= csr_wdata;
            thsq_pkg::CSR_PULL_OFF:     pull_off_ff     <= csr_wdata[thsq_pkg::PULL_OFF_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Next state and axis commands for one pass, in request priority order
   always_comb begin
      mode_in       = mode_ff;
      phase_in      = phase_ff;
      homed_in      = homed_ff;
      home_pend_in  = home_pend_ff;
      start_pend_in = start_pend_ff;
      jog_pend_in   = jog_pend_ff;
      jog_dist_in   = jog_dist_ff;
      act0          = thsq_pkg::ACT_NONE;
      act1          = thsq_pkg::ACT_NONE;
      idle0         = item.left_idle;
      idle1         = item.right_idle;
      moved0        = 1'b0;
      moved1        = 1'b0;
      pos           = item.left_position;
      offset        = '0;
      target        = '0;
      setv          = '0;
      tgt           = '0;
      speed         = thsq_pkg::SPEED_KEEP;
      spin          = thsq_pkg::SPIN_NONE;
      reply         = thsq_pkg::REPLY_OK;
      both          = 1'b0;

      // Latch the request
      if (item.req_type == thsq_pkg::REQ_HOME) begin
         home_pend_in = 1'b1;
      end else if (item.req_type == thsq_pkg::REQ_START) begin
         if (!homed_ff) begin
            reply = thsq_pkg::REPLY_NOT_HOMED;
         end else begin
            start_pend_in = 1'b1;
         end
      end else if (item.req_type == thsq_pkg::REQ_JOG) begin
         if (mode_ff == thsq_pkg::MODE_HOMING || mode_ff == thsq_pkg::MODE_RUN) begin
            reply = thsq_pkg::REPLY_BUSY;
         end else begin
            jog_pend_in = 1'b1;
            jog_dist_in = item.jog_steps;
         end
      end

      // Stop at once and drop every pending request
      if (item.req_type == thsq_pkg::REQ_STOP) begin
         home_pend_in  = 1'b0;
         start_pend_in = 1'b0;
         jog_pend_in   = 1'b0;
         mode_in       = thsq_pkg::MODE_IDLE;
         act0          = thsq_pkg::ACT_STOP;
         act1          = thsq_pkg::ACT_STOP;
         spin          = thsq_pkg::SPIN_STOP;
      end

      // Begin homing with the fast seek
      if (home_pend_in && mode_in == thsq_pkg::MODE_IDLE) begin
         home_pend_in = 1'b0;
         mode_in      = thsq_pkg::MODE_HOMING;
         phase_in     = thsq_pkg::PH_FAST_SEEK;
         speed        = thsq_pkg::SPEED_HALF;
         act0         = thsq_pkg::ACT_MOVE_BY;
         act1         = thsq_pkg::ACT_MOVE_BY;
         offset       = thsq_pkg::SEEK_NEG;
         idle0        = (thsq_pkg::SEEK_NEG == '0);
         idle1        = (thsq_pkg::SEEK_NEG == '0);
         moved0       = 1'b1;
         moved1       = 1'b1;
      end

      // Issue a pending jog
      if (jog_pend_in && mode_in != thsq_pkg::MODE_HOMING && mode_in != thsq_pkg::MODE_RUN) begin
         jog_pend_in = 1'b0;
         speed       = thsq_pkg::SPEED_FULL;
         act0        = thsq_pkg::ACT_MOVE_BY;
         act1        = thsq_pkg::ACT_MOVE_BY;
         offset      = jog_dist_in;
         idle0       = (jog_dist_in == '0);
         idle1       = (jog_dist_in == '0);
         moved0      = 1'b1;
         moved1      = 1'b1;
         mode_in     = thsq_pkg::MODE_JOG;
      end

      // Start winding from the low limit towards the high one
      if (start_pend_in && mode_in == thsq_pkg::MODE_IDLE) begin
         start_pend_in = 1'b0;
         if (homed_ff) begin
            act0    = thsq_pkg::ACT_SET_MOVE;
            act1    = thsq_pkg::ACT_SET_MOVE;
            setv    = lo;
            target  = hi;
            pos     = lo;
            idle0   = (lo == hi);
            idle1   = (lo == hi);
            moved0  = 1'b1;
            moved1  = 1'b1;
            speed   = thsq_pkg::SPEED_FULL;
            spin    = thsq_pkg::SPIN_RUN;
            mode_in = thsq_pkg::MODE_RUN;
         end
      end

      // Emergency stop while active; pending requests stay
      if (item.estop_active && mode_in != thsq_pkg::MODE_IDLE) begin
         mode_in = thsq_pkg::MODE_IDLE;
         act0    = thsq_pkg::ACT_STOP;
         act1    = thsq_pkg::ACT_STOP;
         if (moved0) begin
            idle0 = 1'b1;
         end
         if (moved1) begin
            idle1 = 1'b1;
         end
         spin    = thsq_pkg::SPIN_STOP;
      end

      // Handler of the current mode
      both = idle0 && idle1;
      unique case (mode_in)
         thsq_pkg::MODE_HOMING: begin
            unique case (phase_in)
               thsq_pkg::PH_FAST_SEEK, thsq_pkg::PH_SLOW_SEEK: begin
                  if (item.left_switch_hit) begin
                     act0 = thsq_pkg::ACT_STOP;
                     if (moved0) begin
                        idle0 = 1'b1;
                     end
                  end
                  if (item.right_switch_hit) begin
                     act1 = thsq_pkg::ACT_STOP;
                     if (moved1) begin
                        idle1 = 1'b1;
                     end
                  end
                  if (idle0 && idle1) begin
                     phase_in = (phase_in == thsq_pkg::PH_FAST_SEEK) ?
                                thsq_pkg::PH_WAIT_FAST : thsq_pkg::PH_WAIT_SLOW;
                  end
               end
               thsq_pkg::PH_PULL_AWAY: begin
                  if (!item.left_switch_hit) begin
                     act0 = thsq_pkg::ACT_STOP;
                     if (moved0) begin
                        idle0 = 1'b1;
                     end
                  end
                  if (!item.right_switch_hit) begin
                     act1 = thsq_pkg::ACT_STOP;
                     if (moved1) begin
                        idle1 = 1'b1;
                     end
                  end
                  if (idle0 && idle1) begin
                     phase_in = thsq_pkg::PH_WAIT_PULL;
                  end
               end
               thsq_pkg::PH_WAIT_FAST: begin
                  if (both) begin
                     speed    = thsq_pkg::SPEED_QUARTER;
                     act0     = thsq_pkg::ACT_MOVE_BY;
                     act1     = thsq_pkg::ACT_MOVE_BY;
                     offset   = thsq_pkg::SEEK_POS;
                     phase_in = thsq_pkg::PH_PULL_AWAY;
                  end
               end
               thsq_pkg::PH_WAIT_PULL: begin
                  if (both) begin
                     speed    = thsq_pkg::SPEED_TWENTIETH;
                     act0     = thsq_pkg::ACT_MOVE_BY;
                     act1     = thsq_pkg::ACT_MOVE_BY;
                     offset   = thsq_pkg::SEEK_NEG;
                     phase_in = thsq_pkg::PH_SLOW_SEEK;
                  end
               end
               thsq_pkg::PH_WAIT_SLOW: begin
                  if (both) begin
                     speed    = thsq_pkg::SPEED_FIFTH;
                     act0     = thsq_pkg::ACT_MOVE_BY;
                     act1     = thsq_pkg::ACT_MOVE_BY;
                     offset   = pull_off_ext;
                     phase_in = thsq_pkg::PH_PULL_OFF;
                  end
               end
               default: begin
                  // Pull-off done: load the low limit and head for the high one
                  if (both) begin
                     act0     = thsq_pkg::ACT_SET_MOVE;
                     act1     = thsq_pkg::ACT_SET_MOVE;
                     setv     = lo;
                     target   = hi;
                     speed    = thsq_pkg::SPEED_FULL;
                     mode_in  = thsq_pkg::MODE_IDLE;
                     homed_in = 1'b1;
                  end
               end
            endcase
         end
         thsq_pkg::MODE_RUN: begin
            // Reverse between the limits once both axes have arrived
            if (both) begin
               tgt    = (pos >= hi) ? lo : hi;
               act0   = thsq_pkg::ACT_MOVE_TO;
               act1   = thsq_pkg::ACT_MOVE_TO;
               target = tgt;
            end
         end
         thsq_pkg::MODE_JOG: begin
            if (both) begin
               mode_in = thsq_pkg::MODE_IDLE;
            end
         end
         default: ;
      endcase
   end

   // Assemble the result item
   always_comb begin
      result.left_action    = act0;
      result.right_action   = act1;
      result.move_offset    = offset;
      result.move_target    = target;
      result.set_value      = setv;
      result.speed_code     = speed;
      result.spindle_action = spin;
      result.mode_now       = mode_in;
      result.is_homed       = homed_in;
      result.reply          = reply;
   end

   // Control state: advance once per transfer through the pass
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= thsq_pkg::MODE_IDLE;
         phase_ff      <= thsq_pkg::PH_FAST_SEEK;
         homed_ff      <= 1'b0;
         home_pend_ff  <= 1'b0;
         start_pend_ff <= 1'b0;
         jog_pend_ff   <= 1'b0;
         jog_dist_ff   <= '0;
      end else if (ctrl.advance) begin
         mode_ff       <= mode_in;
         phase_ff      <= phase_in;
         homed_ff      <= homed_in;
         home_pend_ff  <= home_pend_in;
         start_pend_ff <= start_pend_in;
         jog_pend_ff   <= jog_pend_in;
         jog_dist_ff   <= jog_dist_in;
      end
   end

   // Checks on the sequencer state
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (mode_ff == thsq_pkg::MODE_IDLE) && !homed_ff)
      else $error("sequencer not idle and unhomed after reset");

   a_homed_sticks: assert property (@(posedge clock) disable iff (reset)
      homed_ff |=> homed_ff)
      else $error("homed flag dropped");

   a_run_needs_home: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == thsq_pkg::MODE_RUN) |-> homed_ff)
      else $error("running without a completed homing sequence");

   a_hold_without_item: assert property (@(posedge clock) disable iff (reset)
      !ctrl.valid |=> $stable(mode_ff) && $stable(phase_ff))
      else $error("state moved with no pass held");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance && (item.req_type == thsq_pkg::REQ_STOP)
      |=> !home_pend_ff && !start_pend_ff && !jog_pend_ff)
      else $error("stop left a request pending");

endmodule

`default_nettype wire

// ----- hdl/thsq_output_stage.sv -----
// Result register: holds one result item until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module thsq_output_stage (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire thsq_pkg::stage_ctrl_type   ctrl,
   input  wire thsq_pkg::rsp_payload_type  result,
   output logic                            can_load,
   thsq_rsp_if.source                      rsp_if
);

   logic                      valid_ff;
   logic                      valid_in;
   thsq_pkg::rsp_payload_type result_ff;

   // Free when empty or being drained in this cycle
   assign can_load = !valid_ff || rsp_if.ready;

   always_comb begin
      if (ctrl.advance) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the outcome of each pass
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         result_ff <= result;
      end
   end

   assign rsp_if.valid   = valid_ff;
   assign rsp_if.payload = result_ff;

endmodule

`default_nettype wire

// ----- hdl/traverse_homing_winding_sequencer.sv -----
// Top level of the dual-axis traverse homing and winding sequencer.
//
//   channel  | direction | handshake          | carries
//   ---------+-----------+--------------------+-------------------------------------
//   req_if   | in        | valid / ready      | control pass, optional command
//   rsp_if   | out       | valid / ready      | axis actions, speed, spindle, status
//   csr_*    | in        | write enable only  | traverse limits, pull-off distance
//
// One pass per cycle sustained while rsp_if is ready; a pass is held in the input register
// and then in the result register before it appears on rsp_if.
// The loop through mode, homing phase and pending requests closes through the core state registers.
// Reset clears mode, phase, homed flag and pending requests, and loads register defaults.
// A stalled rsp_if holds its result; req_if keeps taking transfers until both
// the result register and the input register are full.
`timescale 1ns / 1ps
`default_nettype none

module traverse_homing_winding_sequencer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   thsq_req_if.sink                                 req_if,
   thsq_rsp_if.source                               rsp_if,
   input  wire logic                                csr_wr_en,
   input  wire logic [thsq_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [thsq_pkg::POS_WIDTH-1:0]      csr_wdata
);

   thsq_pkg::stage_ctrl_type  ctrl;
   thsq_pkg::req_payload_type item;
   thsq_pkg::rsp_payload_type result;
   logic                      can_load;

   thsq_input_stage u_input (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .can_load (can_load),
      .ctrl     (ctrl),
      .item     (item)
   );

   thsq_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .item      (item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   thsq_output_stage u_output (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .result   (result),
      .can_load (can_load),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire
